### sv/mhse_pkg.sv
// ----------------------------------------------------------------------------
// mhse_pkg
// Shared types and constants for the min-heap sift engine: opcodes, controller
// states, memory port selects and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package mhse_pkg;

  // Fixed field widths of the stream and configuration ports
  localparam int OPCODE_W    = 3;
  localparam int INDEX_W     = 10;
  localparam int KEY_IN_W    = 32;
  localparam int COUNT_W     = 11;
  localparam int SWAP_W      = 4;
  localparam int IN_TDATA_W  = 48;  // index, key, zero pad
  localparam int OUT_TDATA_W = 40;  // read_key, swap_count, index_error, zero pad

  // Operation codes carried in in_tuser
  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE   = 3'd0,
    OP_READ    = 3'd1,
    OP_SIFT_DN = 3'd2,
    OP_SIFT_UP = 3'd3,
    OP_BUILD   = 3'd4
  } op_t;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_ISSUE,
    S_LOAD,
    S_DN_LEFT,
    S_DN_RIGHT,
    S_DN_CMP,
    S_UP_PARENT,
    S_UP_CMP,
    S_PLACE,
    S_DONE
  } state_t;

  // Memory read address select
  typedef enum logic [1:0] {
    RS_POS,
    RS_LEFT,
    RS_RIGHT,
    RS_PARENT
  } rsel_t;

  // Memory write data select
  typedef enum logic [1:0] {
    WS_KEY,
    WS_DN,
    WS_UP,
    WS_CUR
  } wsel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic  capture;     // latch an accepted input transfer
    logic  mem_wr;      // write memory at the current position
    wsel_t wsel;
    logic  mem_rd;      // issue a memory read
    rsel_t rsel;
    logic  set_err;     // flag sift index out of range
    logic  rd_capture;  // latch read data as the read result
    logic  load_cur;    // latch the moving key
    logic  dn_left;     // compare left child against the moving key
    logic  dn_step;     // move one level down
    logic  up_step;     // move one level up
    logic  build_start; // start build at position one
    logic  build_next;  // advance build to the next position
    logic  out_load;    // load the result register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    op_t  op;
    logic idx_ok;       // index lies inside the memory
    logic idx_err;      // index at or beyond the live count
    logic build_empty;  // live count of zero or one
    logic left_ok;      // left child exists
    logic dn_swap;      // a child is strictly smaller
    logic pos_zero;     // position is the root
    logic up_swap;      // parent is strictly larger
    logic build_more;   // build has positions left
  } dp_status_t;

endpackage

### sv/mhse_ctrl.sv
// ----------------------------------------------------------------------------
// mhse_ctrl
// Controller of the min-heap sift engine: sequences write, read, sift down,
// sift up and build over the datapath and owns the stream handshakes.
// ----------------------------------------------------------------------------
module mhse_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  mhse_pkg::dp_status_t  status,
  output mhse_pkg::ctrl_cmd_t   cmd
);
  import mhse_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result slot: fill on load, drain on transfer
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        // Hold off the input while reset is asserted
        in_tready = rst_n;
        if (in_tvalid && rst_n) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (status.op)
          OP_WRITE: begin
            cmd.mem_wr = status.idx_ok;
            cmd.wsel   = WS_KEY;
            state_nxt  = S_DONE;
          end
          OP_READ: begin
            if (status.idx_ok) begin
              cmd.mem_rd = 1'b1;
              cmd.rsel   = RS_POS;
              state_nxt  = S_READ;
            end else begin
              state_nxt  = S_DONE;
            end
          end
          OP_SIFT_DN, OP_SIFT_UP: begin
            if (status.idx_err) begin
              cmd.set_err = 1'b1;
              state_nxt   = S_DONE;
            end else begin
              state_nxt   = S_ISSUE;
            end
          end
          OP_BUILD: begin
            if (status.build_empty) begin
              state_nxt = S_DONE;
            end else begin
              cmd.build_start = 1'b1;
              state_nxt       = S_ISSUE;
            end
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_READ: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = S_DONE;
      end
      S_ISSUE: begin
        cmd.mem_rd = 1'b1;
        cmd.rsel   = RS_POS;
        state_nxt  = S_LOAD;
      end
      S_LOAD: begin
        cmd.load_cur = 1'b1;
        state_nxt    = (status.op == OP_SIFT_DN) ? S_DN_LEFT : S_UP_PARENT;
      end
      S_DN_LEFT: begin
        if (status.left_ok) begin
          cmd.mem_rd = 1'b1;
          cmd.rsel   = RS_LEFT;
          state_nxt  = S_DN_RIGHT;
        end else begin
          state_nxt  = S_PLACE;
        end
      end
      S_DN_RIGHT: begin
        cmd.mem_rd  = 1'b1;
        cmd.rsel    = RS_RIGHT;
        cmd.dn_left = 1'b1;
        state_nxt   = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (status.dn_swap) begin
          cmd.mem_wr  = 1'b1;
          cmd.wsel    = WS_DN;
          cmd.dn_step = 1'b1;
          state_nxt   = S_DN_LEFT;
        end else begin
          state_nxt   = S_PLACE;
        end
      end
      S_UP_PARENT: begin
        if (status.pos_zero) begin
          state_nxt  = S_PLACE;
        end else begin
          cmd.mem_rd = 1'b1;
          cmd.rsel   = RS_PARENT;
          state_nxt  = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (status.up_swap) begin
          cmd.mem_wr  = 1'b1;
          cmd.wsel    = WS_UP;
          cmd.up_step = 1'b1;
          state_nxt   = S_UP_PARENT;
        end else begin
          state_nxt   = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd.mem_wr = 1'b1;
        cmd.wsel   = WS_CUR;
        if (status.op == OP_BUILD && status.build_more) begin
          cmd.build_next = 1'b1;
          state_nxt      = S_ISSUE;
        end else begin
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // The key memory is never asked to read and write in one cycle
  a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.mem_rd && cmd.mem_wr))
    else $error("memory read and write issued together");

  // A result is loaded only into a free or draining slot
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result register overwritten");

  // The moving key is latched in the cycle after its read was issued
  a_load_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |-> $past(state_r == S_ISSUE))
    else $error("key load without preceding read");

  // The child compare sees the right child read issued in the cycle before
  a_cmp_after_right: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DN_CMP) |-> $past(state_r == S_DN_RIGHT))
    else $error("child compare out of sequence");

  // An accepted transfer is dispatched in the next cycle
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == S_DISPATCH))
    else $error("accepted item not dispatched");

endmodule

### sv/mhse_dp.sv
// ----------------------------------------------------------------------------
// mhse_dp
// Datapath of the min-heap sift engine: key memory, position and key
// registers, child/parent address math, compares, count register and the
// result register.
// ----------------------------------------------------------------------------
module mhse_dp #(
  parameter int HEAP_DEPTH = 1024,
  parameter int KEY_WIDTH  = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [mhse_pkg::COUNT_W-1:0]       cfg_wr_data,
  input  logic [mhse_pkg::OPCODE_W-1:0]      in_opcode,
  input  logic [mhse_pkg::INDEX_W-1:0]       in_index,
  input  logic [mhse_pkg::KEY_IN_W-1:0]      in_key,
  input  mhse_pkg::ctrl_cmd_t                cmd,
  output mhse_pkg::dp_status_t               status,
  output logic [mhse_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import mhse_pkg::*;

  localparam int AW = $clog2(HEAP_DEPTH);      // memory address width
  localparam int CW = $clog2(HEAP_DEPTH + 1);  // live count width
  localparam int PW = AW + 2;                  // child position width
  localparam int KW = KEY_WIDTH;

  // Key memory, read data registered
  logic [KW-1:0] mem [HEAP_DEPTH];
  logic [KW-1:0] mem_q;
  logic [AW-1:0] rd_addr;
  logic [KW-1:0] wdata;

  // Item and walk registers
  logic [COUNT_W-1:0]  count_r;
  op_t                 op_r;
  logic [INDEX_W-1:0]  idx_r;
  logic [KEY_IN_W-1:0] key_r;
  logic [AW-1:0]       pos_r;
  logic [AW-1:0]       build_i_r;
  logic [KW-1:0]       cur_key_r;
  logic [KW-1:0]       best_key_r;
  logic                best_child_r;
  logic [SWAP_W-1:0]   swaps_r;
  logic                err_r;
  logic [KEY_IN_W-1:0] rd_key_r;

  // Result register
  logic [KEY_IN_W-1:0] out_key_r;
  logic [SWAP_W-1:0]   out_swaps_r;
  logic                out_err_r;

  // Derived positions
  logic [CW-1:0] live_n;
  logic [PW-1:0] n_w;
  logic [PW-1:0] left_w;
  logic [PW-1:0] right_w;
  logic [AW-1:0] pos_m1;
  logic [AW-1:0] parent;
  logic          right_ok;
  logic          right_better;
  logic [KW-1:0] dn_key;
  logic [AW-1:0] dn_pos;

  // Clamp the configured count to the memory depth
  assign live_n  = (32'(count_r) > 32'(HEAP_DEPTH)) ? CW'(HEAP_DEPTH) : CW'(count_r);
  assign n_w     = PW'(live_n);
  assign left_w  = PW'({pos_r, 1'b1});
  assign right_w = left_w + PW'(1);
  assign pos_m1  = pos_r - AW'(1);
  assign parent  = pos_m1 >> 1;

  // Pick the strictly smaller child, left wins ties
  assign right_ok     = right_w < n_w;
  assign right_better = right_ok && (mem_q < best_key_r);
  assign dn_key       = right_better ? mem_q : best_key_r;
  assign dn_pos       = right_better ? right_w[AW-1:0] : left_w[AW-1:0];

  // Status to the controller
  always_comb begin
    status.op          = op_r;
    status.idx_ok      = 32'(idx_r) < 32'(HEAP_DEPTH);
    status.idx_err     = 32'(idx_r) >= 32'(live_n);
    status.build_empty = n_w <= PW'(1);
    status.left_ok     = left_w < n_w;
    status.dn_swap     = best_child_r || right_better;
    status.pos_zero    = pos_r == '0;
    status.up_swap     = cur_key_r < mem_q;
    status.build_more  = (PW'(build_i_r) + PW'(1)) < n_w;
  end

  // Read address and write data selection
  always_comb begin
    unique case (cmd.rsel)
      RS_POS:    rd_addr = pos_r;
      RS_LEFT:   rd_addr = left_w[AW-1:0];
      RS_RIGHT:  rd_addr = right_w[AW-1:0];
      RS_PARENT: rd_addr = parent;
      default:   rd_addr = pos_r;
    endcase
    unique case (cmd.wsel)
      WS_KEY:  wdata = KW'(key_r);
      WS_DN:   wdata = dn_key;
      WS_UP:   wdata = mem_q;
      WS_CUR:  wdata = cur_key_r;
      default: wdata = cur_key_r;
    endcase
  end

  // Key memory: one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) begin
      mem[pos_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cfg_wr_en) begin
      count_r <= cfg_wr_data;
    end
  end

  // Item capture and walk registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= op_t'(in_opcode);
      idx_r    <= in_index;
      key_r    <= in_key;
      pos_r    <= AW'(in_index);
      swaps_r  <= '0;
      err_r    <= 1'b0;
      rd_key_r <= '0;
    end
    if (cmd.set_err) begin
      err_r <= 1'b1;
    end
    if (cmd.rd_capture) begin
      rd_key_r <= KEY_IN_W'(mem_q);
    end
    if (cmd.load_cur) begin
      cur_key_r <= mem_q;
    end
    // Left child becomes the candidate only when strictly smaller
    if (cmd.dn_left) begin
      if (mem_q < cur_key_r) begin
        best_key_r   <= mem_q;
        best_child_r <= 1'b1;
      end else begin
        best_key_r   <= cur_key_r;
        best_child_r <= 1'b0;
      end
    end
    if (cmd.dn_step || cmd.up_step) begin
      if (swaps_r != '1) begin
        swaps_r <= swaps_r + SWAP_W'(1);
      end
    end
    if (cmd.dn_step) begin
      pos_r <= dn_pos;
    end
    if (cmd.up_step) begin
      pos_r <= parent;
    end
    if (cmd.build_start) begin
      pos_r     <= AW'(1);
      build_i_r <= AW'(1);
    end
    if (cmd.build_next) begin
      pos_r     <= build_i_r + AW'(1);
      build_i_r <= build_i_r + AW'(1);
    end
  end

  // Result register; build reports no swaps
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_key_r   <= rd_key_r;
      out_swaps_r <= (op_r == OP_BUILD) ? '0 : swaps_r;
      out_err_r   <= err_r;
    end
  end

  assign out_tdata = {3'b000, out_err_r, out_swaps_r, out_key_r};

endmodule

### sv/min_heap_sift_engine.sv
// ----------------------------------------------------------------------------
// min_heap_sift_engine
// Binary min-heap engine over a key memory: write, read, sift down, sift up
// and build, one operation per input transfer, one result per operation.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: in_tuser carries the opcode, in_tdata the index and key.
//   Output stream: one transfer per input with read key, swap count and the
//   sift index error flag. cfg_wr_en/cfg_wr_data set the element count and
//   may only be written while no operation is in flight.
// Sift down reads the left and then the right child at each level walked;
//   sift up reads the parent at each level walked; build sifts up each
//   position from 1 to count-1 in turn. Operations run one at a time; the
//   next item is accepted in the cycle after the result is loaded.
// Reset: rst_n clears the count and the control state; the key memory is not
//   cleared and an entry must be written before it is read or sifted over.
// Stall: a held result keeps out_tvalid high; the engine accepts one more
//   item, runs it and waits in its final state until the output frees.
// ----------------------------------------------------------------------------
module min_heap_sift_engine #(
  parameter int HEAP_DEPTH = 1024,
  parameter int KEY_WIDTH  = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Configuration
  input  logic                                cfg_wr_en,
  input  logic [mhse_pkg::COUNT_W-1:0]        cfg_wr_data,   // element_count
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [mhse_pkg::IN_TDATA_W-1:0]     in_tdata,      // [9:0] index, [41:10] key
  input  logic [mhse_pkg::OPCODE_W-1:0]       in_tuser,      // [2:0] opcode
  // Output stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [mhse_pkg::OUT_TDATA_W-1:0]    out_tdata      // [31:0] read_key,
                                                             // [35:32] swap_count,
                                                             // [36] index_error
);
  import mhse_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer
  mhse_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // Memory and arithmetic
  mhse_dp #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_opcode   (in_tuser),
    .in_index    (in_tdata[INDEX_W-1:0]),
    .in_key      (in_tdata[INDEX_W+KEY_IN_W-1:INDEX_W]),
    .cmd         (cmd),
    .status      (status),
    .out_tdata   (out_tdata)
  );

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the min-heap sift engine. A directed table covers
// reset state, out-of-range sifts, unused opcodes, key extremes and sift ties.
// Randomized phases with different element counts then follow. Every accepted
// operation is run through a local heap predictor, and each output transfer
// is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mhse_pkg::*;

  localparam int HEAP_DEPTH    = 1024;
  localparam int KEY_WIDTH     = 32;
  localparam int N_PHASES      = 12;
  localparam int PHASE_ITEMS   = 84;
  localparam int LONG_HOLD     = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES  = 3000000;

  // Opcodes the block does not define
  localparam logic [OPCODE_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [31:0]       read_key;
    logic [SWAP_W-1:0] swap_count;
    logic              index_error;
  } heap_result_t;

  typedef struct packed {
    logic                is_cfg;
    logic                typed;
    logic [COUNT_W-1:0]  count;
    logic [OPCODE_W-1:0] op;
    logic [INDEX_W-1:0]  idx;
    logic [KEY_IN_W-1:0] key;
    heap_result_t        want;
  } stim_row_t;

  localparam heap_result_t NO_RESULT  = '0;
  localparam heap_result_t ERR_RESULT = '{32'h0, 4'd0, 1'b1};

  // Directed stimulus; typed rows carry their expected result
  localparam int N_DIR = 28;
  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    // count is still at its reset value of zero
    '{1'b0, 1'b1, 11'd0, OP_SIFT_DN, 10'd0,    32'h0,        ERR_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_SIFT_UP, 10'd1023, 32'h0,        ERR_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_BUILD,   10'd0,    32'h0,        NO_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_SPARE_5, 10'd1023, 32'hffffffff, NO_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_SPARE_6, 10'd0,    32'h0,        NO_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_SPARE_7, 10'd512,  32'ha5a5a5a5, NO_RESULT},
    // key extremes at both ends of the store
    '{1'b0, 1'b1, 11'd0, OP_WRITE,   10'd1023, 32'hffffffff, NO_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_READ,    10'd1023, 32'h0,  '{32'hffffffff, 4'd0, 1'b0}},
    '{1'b0, 1'b1, 11'd0, OP_WRITE,   10'd0,    32'h0,        NO_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_READ,    10'd0,    32'hffffffff, NO_RESULT},
    // four-entry heap with equal children and equal parent
    '{1'b1, 1'b0, 11'd4, OP_WRITE,   10'd0,    32'h0,        NO_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_WRITE,   10'd1,    32'd7,        NO_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_WRITE,   10'd2,    32'd7,        NO_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_WRITE,   10'd3,    32'd3,        NO_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_WRITE,   10'd0,    32'd9,        NO_RESULT},
    '{1'b0, 1'b0, 11'd0, OP_SIFT_DN, 10'd0,    32'h0,        NO_RESULT},
    '{1'b0, 1'b0, 11'd0, OP_SIFT_UP, 10'd3,    32'h0,        NO_RESULT},
    '{1'b0, 1'b0, 11'd0, OP_SIFT_UP, 10'd1,    32'h0,        NO_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_WRITE,   10'd2,    32'd3,        NO_RESULT},
    '{1'b0, 1'b0, 11'd0, OP_SIFT_UP, 10'd2,    32'h0,        NO_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_SIFT_DN, 10'd4,    32'h0,        ERR_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_WRITE,   10'd0,    32'hffffffff, NO_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_BUILD,   10'd0,    32'h0,        NO_RESULT},
    '{1'b0, 1'b0, 11'd0, OP_READ,    10'd0,    32'h0,        NO_RESULT},
    '{1'b0, 1'b0, 11'd0, OP_READ,    10'd3,    32'h0,        NO_RESULT},
    // single-entry heap
    '{1'b1, 1'b0, 11'd1, OP_WRITE,   10'd0,    32'h0,        NO_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_BUILD,   10'd0,    32'h0,        NO_RESULT},
    '{1'b0, 1'b1, 11'd0, OP_SIFT_UP, 10'd1,    32'h0,        ERR_RESULT}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0]     cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;     // [9:0] index, [41:10] key
  logic [OPCODE_W-1:0]    in_tuser = '0;     // [2:0] opcode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // [31:0] read_key, [35:32] swap_count,
                                             // [36] index_error

  min_heap_sift_engine #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // Heap predictor state
  logic [KEY_WIDTH-1:0] key_store [HEAP_DEPTH];
  logic [COUNT_W-1:0]   elem_count;

  // Entries written so far; sifts and reads only touch these
  bit                   written [HEAP_DEPTH];
  int unsigned          written_list [$];

  heap_result_t         pending_results [$];
  int                   mismatches;
  int unsigned          cycle_cnt;
  int unsigned          sent_cnt;
  int unsigned          checked_cnt;
  int unsigned          build_cnt;
  int unsigned          max_swaps;
  int unsigned          sender_quiet;
  int unsigned          receiver_quiet;
  bit                   hold_output_req;
  bit                   receiver_on;
  int unsigned          key_mode;

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_cnt, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned live_entries();
    return (elem_count > HEAP_DEPTH) ? HEAP_DEPTH : int'(elem_count);
  endfunction

  function automatic void swap_keys(int unsigned a, int unsigned b);
    logic [KEY_WIDTH-1:0] t;
    t            = key_store[a];
    key_store[a] = key_store[b];
    key_store[b] = t;
  endfunction

  // Move the key at pos down past strictly smaller children (left on a tie)
  function automatic int unsigned sink_key(int unsigned pos, int unsigned n);
    int unsigned swaps;
    int unsigned best;
    int unsigned l;
    int unsigned r;
    swaps = 0;
    while (1'b1) begin
      best = pos;
      l    = 2 * pos + 1;
      r    = 2 * pos + 2;
      if (l < n && key_store[l] < key_store[best]) best = l;
      if (r < n && key_store[r] < key_store[best]) best = r;
      if (best == pos) break;
      swap_keys(pos, best);
      swaps++;
      pos = best;
    end
    return swaps;
  endfunction

  // Move the key at pos up past strictly larger parents
  function automatic int unsigned swim_key(int unsigned pos);
    int unsigned swaps;
    int unsigned up;
    swaps = 0;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!(key_store[pos] < key_store[up])) break;
      swap_keys(pos, up);
      swaps++;
      pos = up;
    end
    return swaps;
  endfunction

  function automatic heap_result_t apply_heap_op(logic [OPCODE_W-1:0] op,
                                                 logic [INDEX_W-1:0] idx,
                                                 logic [KEY_IN_W-1:0] key);
    heap_result_t res;
    int unsigned  n;
    int unsigned  swaps;
    int unsigned  i;
    res   = '0;
    swaps = 0;
    n     = live_entries();
    case (op)
      OP_WRITE: key_store[idx] = key[KEY_WIDTH-1:0];
      OP_READ: res.read_key = key_store[idx];
      OP_SIFT_DN: begin
        if (idx >= n) res.index_error = 1'b1;
        else swaps = sink_key(idx, n);
      end
      OP_SIFT_UP: begin
        if (idx >= n) res.index_error = 1'b1;
        else swaps = swim_key(idx);
      end
      OP_BUILD: begin
        for (i = 1; i < n; i++) void'(swim_key(i));
      end
      default: ;
    endcase
    res.swap_count = (swaps > 15) ? 4'd15 : swaps[SWAP_W-1:0];
    return res;
  endfunction

  // Check each output transfer against the oldest prediction
  always @(posedge clk) begin
    heap_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected: expected none, got %h", $time,
                 out_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        checked_cnt++;
        if (out_tdata[31:0] != want.read_key) begin
          $display("%0t: read_key mismatch: expected %h, got %h", $time,
                   want.read_key, out_tdata[31:0]);
          mismatches++;
        end
        if (out_tdata[35:32] != want.swap_count) begin
          $display("%0t: swap_count mismatch: expected %0d, got %0d", $time,
                   want.swap_count, out_tdata[35:32]);
          mismatches++;
        end
        if (out_tdata[36] != want.index_error) begin
          $display("%0t: index_error mismatch: expected %0d, got %0d", $time,
                   want.index_error, out_tdata[36]);
          mismatches++;
        end
        if (out_tdata[35:32] > max_swaps) max_swaps = out_tdata[35:32];
      end
    end
  end

  // Output side: random stalls, quiet stretches and one long hold on request
  initial begin
    int unsigned stall;
    wait (receiver_on);
    forever begin
      if (hold_output_req) begin
        stall           = LONG_HOLD;
        hold_output_req = 1'b0;
      end else if (receiver_quiet > 0) begin
        stall = 0;
        receiver_quiet--;
      end else begin
        if ($urandom_range(0, 19) == 0) receiver_quiet = $urandom_range(10, 40);
        stall = $urandom_range(0, 13);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic int unsigned draw_in_gap();
    if (sender_quiet > 0) begin
      sender_quiet--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) sender_quiet = $urandom_range(10, 40);
    return $urandom_range(0, 13);
  endfunction

  // Offer one item, hold it until transferred, then predict its result
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [INDEX_W-1:0] idx,
                           input logic [KEY_IN_W-1:0] key, input bit typed = 1'b0,
                           input heap_result_t want = '0);
    int unsigned  gap;
    heap_result_t predicted;
    gap = draw_in_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(IN_TDATA_W - KEY_IN_W - INDEX_W){1'b0}}, key, idx};
    do @(posedge clk); while (!in_tready);
    predicted = apply_heap_op(op, idx, key);
    pending_results.push_back(typed ? want : predicted);
    sent_cnt++;
    if (op == OP_BUILD) build_cnt++;
    if (op == OP_WRITE && !written[idx]) begin
      written[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endtask

  // Drop valid after the last transfer
  task automatic release_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the element count with nothing in flight
  task automatic set_count(input logic [COUNT_W-1:0] value);
    release_input();
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    elem_count  = value;
  endtask

  function automatic logic [KEY_IN_W-1:0] draw_key();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return (key_mode == 0) ? KEY_IN_W'($urandom) : KEY_IN_W'($urandom_range(0, 15));
    endcase
  endfunction

  // Sift start: mostly inside the live heap, sometimes at or past its end
  function automatic logic [INDEX_W-1:0] draw_sift_index(int unsigned n);
    if (n == 0) return INDEX_W'($urandom_range(0, HEAP_DEPTH - 1));
    if (n < HEAP_DEPTH && $urandom_range(0, 9) == 0)
      return INDEX_W'($urandom_range(n, HEAP_DEPTH - 1));
    return INDEX_W'($urandom_range(0, n - 1));
  endfunction

  // Write every live entry that has never been written
  task automatic fill_live_entries();
    int unsigned i;
    for (i = 0; i < live_entries(); i++) begin
      if (!written[i]) send_item(OP_WRITE, INDEX_W'(i), KEY_IN_W'($urandom));
    end
  endtask

  task automatic random_item();
    int unsigned         sel;
    int unsigned         n;
    logic [INDEX_W-1:0]  idx;
    logic [KEY_IN_W-1:0] key;
    sel = $urandom_range(0, 99);
    n   = live_entries();
    key = draw_key();
    if (sel < 18) begin
      if (n > 0 && $urandom_range(0, 1) == 0) idx = INDEX_W'($urandom_range(0, n - 1));
      else idx = INDEX_W'($urandom_range(0, HEAP_DEPTH - 1));
      send_item(OP_WRITE, idx, key);
    end else if (sel < 32) begin
      idx = INDEX_W'(written_list[$urandom_range(0, written_list.size() - 1)]);
      send_item(OP_READ, idx, KEY_IN_W'($urandom));
    end else if (sel < 55) begin
      send_item(OP_SIFT_DN, draw_sift_index(n), KEY_IN_W'($urandom));
    end else if (sel < 76) begin
      send_item(OP_SIFT_UP, draw_sift_index(n), KEY_IN_W'($urandom));
    end else if (sel < 84 && n > 0) begin
      // insert: small key at a random slot, then let it climb
      idx = INDEX_W'($urandom_range(0, n - 1));
      if ($urandom_range(0, 7) == 0) idx = INDEX_W'(n - 1);
      send_item(OP_WRITE, idx, KEY_IN_W'($urandom_range(0, 15)));
      send_item(OP_SIFT_UP, idx, KEY_IN_W'($urandom));
    end else if (sel < 92 && n > 0) begin
      // replace the root, then let it sink
      send_item(OP_WRITE, '0, ($urandom_range(0, 1) == 0) ? '1 : key);
      send_item(OP_SIFT_DN, '0, KEY_IN_W'($urandom));
    end else if (sel < 97) begin
      // keep builds over large heaps rare, they sift up from every position
      if (n <= 64 || $urandom_range(0, 4) == 0)
        send_item(OP_BUILD, INDEX_W'($urandom), KEY_IN_W'($urandom));
      else
        send_item(OP_SIFT_UP, draw_sift_index(n), KEY_IN_W'($urandom));
    end else begin
      case ($urandom_range(0, 2))
        0: send_item(OP_SPARE_5, INDEX_W'($urandom), KEY_IN_W'($urandom));
        1: send_item(OP_SPARE_6, INDEX_W'($urandom), KEY_IN_W'($urandom));
        default: send_item(OP_SPARE_7, INDEX_W'($urandom), KEY_IN_W'($urandom));
      endcase
    end
  endtask

  function automatic logic [COUNT_W-1:0] phase_count(int unsigned ph);
    case (ph)
      0: return 11'd1;
      1: return 11'd0;
      2: return 11'd2;
      4: return 11'd1024;
      6: return 11'd2047;
      7: return COUNT_W'($urandom_range(1025, 2046));
      8: return 11'd1023;
      10: return 11'd3;
      default: return COUNT_W'($urandom_range(4, 63));
    endcase
  endfunction

  // Main stimulus
  initial begin
    int unsigned ph;
    int unsigned k;
    int unsigned r;
    elem_count = '0;
    for (r = 0; r < HEAP_DEPTH; r++) key_store[r] = '0;
    repeat (12) @(posedge clk);
    rst_n       <= 1'b1;
    receiver_on  = 1'b1;
    @(posedge clk);

    // Directed table
    for (r = 0; r < N_DIR; r++) begin
      if (DIR_ROWS[r].is_cfg) set_count(DIR_ROWS[r].count);
      else send_item(DIR_ROWS[r].op, DIR_ROWS[r].idx, DIR_ROWS[r].key,
                     DIR_ROWS[r].typed, DIR_ROWS[r].want);
    end

    // Random phases, each under its own element count
    for (ph = 0; ph < N_PHASES; ph++) begin
      set_count(phase_count(ph));
      key_mode = $urandom_range(0, 1);
      fill_live_entries();
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // hold off the output so the engine backs up into its input
        if (k == 40 && (ph == 3 || ph == 9)) hold_output_req = 1'b1;
        // pause the input until everything has come back
        if (k == 40 && (ph == 5 || ph == 11)) begin
          release_input();
          wait_drained();
        end
        random_item();
      end
    end

    release_input();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d operations over %0d count settings, %0d results checked",
             sent_cnt, N_PHASES + 3, checked_cnt);
    $display("builds %0d, largest swap count %0d, mismatches %0d",
             build_cnt, max_swaps, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
